[sv/vmsu_pkg.sv]
// ----------------------------------------------------------------------------
// vmsu_pkg: shared types and constants for the Maxwell stress update
// Widths of the strain, auxiliary strain and stress words, the register
// indexes of the configuration port, and the saturation helper.
// ----------------------------------------------------------------------------
package vmsu_pkg;

    localparam int VOIGT_COMPONENTS = 6;
    localparam int NORMAL_ROWS      = 3;

    localparam int STRAIN_W = 32;
    localparam int STRESS_W = 48;
    localparam int COEF_W   = 16;
    localparam int MOD_W    = 32;
    localparam int FACT_W   = COEF_W + 1;   // Q1.16 strain factors
    localparam int AUX_W    = 34;           // rounded auxiliary strain, Q.30
    localparam int ALO_W    = 14;           // low part of the split
    localparam int AHI_W    = AUX_W - ALO_W;
    localparam int SUM_W    = 58;           // matrix term plus decayed stress

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEAR    = 3'd4;

    typedef logic signed [STRAIN_W-1:0] strain_t;
    typedef logic signed [STRESS_W-1:0] stress_t;
    typedef logic signed [AHI_W-1:0]    ahi_t;
    typedef logic        [ALO_W-1:0]    alo_t;

    typedef struct packed {
        logic mul_en;   // lanes register their two strain products
        logic aux_en;   // lanes register the rounded and split aux strain
        logic mat_en;   // merge stage registers the matrix and decay products
    } ctrl_t;

    localparam stress_t STRESS_MAX = {1'b0, {(STRESS_W-1){1'b1}}};
    localparam stress_t STRESS_MIN = {1'b1, {(STRESS_W-1){1'b0}}};

    // Clamp a wide signed sum to the stress range.
    function automatic stress_t sat_stress(input logic signed [SUM_W-1:0] x);
        logic all_ones;
        logic all_zeros;
        all_ones  = &x[SUM_W-1:STRESS_W-1];
        all_zeros = ~|x[SUM_W-1:STRESS_W-1];
        if (all_ones || all_zeros) begin
            return x[STRESS_W-1:0];
        end else if (x[SUM_W-1]) begin
            return STRESS_MIN;
        end else begin
            return STRESS_MAX;
        end
    endfunction

endpackage

[sv/viscoelastic_maxwell_stress_update_top.sv]
// ----------------------------------------------------------------------------
// viscoelastic_maxwell_stress_update_top: one Maxwell branch stress update
// Takes a six-component Voigt strain item and returns the six-component
// stress item; a commit bit keeps the strain and the stress as history.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake               Payload
//  -------  ----------------------  ------------------------------------------
//  input    in_valid / in_ready     strain_xx .. strain_xz (Q1.30), commit
//  output   out_valid / out_ready   stress_xx .. stress_xz (Q32.16, saturated)
//  config   cfg_valid / cfg_ready   cfg_index (register), cfg_data
//
//  An item passes, after acceptance, through the previous-strain factor,
//  the lane products, the rounded aux strain, the matrix products and the
//  final sum, each in a registered state of its own, to a valid result.
//  Each item needs the history that the one before may commit, so in_ready
//  rises again only when a result has been loaded into the output register;
//  so a new item is accepted only once the one before has finished.
//  A stalled output holds the last result; the next item is still accepted
//  and waits in the sum step until the output register frees up.
//  Reset clears the configuration registers and the strain and stress history.
//
module viscoelastic_maxwell_stress_update_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vmsu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vmsu_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  vmsu_pkg::strain_t                   strain_xx,
    input  vmsu_pkg::strain_t                   strain_yy,
    input  vmsu_pkg::strain_t                   strain_zz,
    input  vmsu_pkg::strain_t                   strain_xy,
    input  vmsu_pkg::strain_t                   strain_yz,
    input  vmsu_pkg::strain_t                   strain_xz,
    input  logic                                commit,
    output logic                                out_valid,
    input  logic                                out_ready,
    output vmsu_pkg::stress_t                   stress_xx,
    output vmsu_pkg::stress_t                   stress_yy,
    output vmsu_pkg::stress_t                   stress_zz,
    output vmsu_pkg::stress_t                   stress_xy,
    output vmsu_pkg::stress_t                   stress_yz,
    output vmsu_pkg::stress_t                   stress_xz
);
    import vmsu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FP,
        ST_MUL,
        ST_AUX,
        ST_MAT,
        ST_SUM
    } state_t;

    localparam int FP_PROD_W = COEF_W + FACT_W;

    // Configuration registers.
    logic [COEF_W-1:0] decay_reg;
    logic [COEF_W-1:0] coef_reg;
    logic [MOD_W-1:0]  normal_reg;
    logic [MOD_W-1:0]  coupling_reg;
    logic [MOD_W-1:0]  shear_reg;

    state_t            state_reg;
    logic              commit_reg;
    logic              out_valid_reg;
    strain_t           strain_reg      [VOIGT_COMPONENTS];
    strain_t           prev_strain_reg [VOIGT_COMPONENTS];
    stress_t           prev_stress_reg [VOIGT_COMPONENTS];
    stress_t           stress_reg      [VOIGT_COMPONENTS];
    logic [FACT_W-1:0] fp_reg;

    strain_t           strain_in  [VOIGT_COMPONENTS];
    stress_t           stress_sum [VOIGT_COMPONENTS];
    ahi_t              ahi        [VOIGT_COMPONENTS];
    alo_t              alo        [VOIGT_COMPONENTS];
    logic [FP_PROD_W-1:0] fp_prod;
    logic [FACT_W-1:0] fp_next;
    logic [FACT_W-1:0] fc;
    logic              in_accept;
    logic              result_load;
    ctrl_t             ctrl;

    assign strain_in[0] = strain_xx;
    assign strain_in[1] = strain_yy;
    assign strain_in[2] = strain_zz;
    assign strain_in[3] = strain_xy;
    assign strain_in[4] = strain_yz;
    assign strain_in[5] = strain_xz;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg    <= '0;
            coef_reg     <= '0;
            normal_reg   <= '0;
            coupling_reg <= '0;
            shear_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DECAY:    decay_reg    <= cfg_data[COEF_W-1:0];
                CFG_COEF:     coef_reg     <= cfg_data[COEF_W-1:0];
                CFG_NORMAL:   normal_reg   <= cfg_data[MOD_W-1:0];
                CFG_COUPLING: coupling_reg <= cfg_data[MOD_W-1:0];
                CFG_SHEAR:    shear_reg    <= cfg_data[MOD_W-1:0];
                default:      ;
            endcase
        end
    end

    // Previous-strain factor decay * (1 + coef), rounded back to Q1.16, and
    // the current-strain factor 1 - coef, which reaches 1.0 when coef is zero.
    assign fp_prod = FP_PROD_W'(decay_reg) * (FP_PROD_W'(coef_reg) + FP_PROD_W'(65536));
    assign fp_next = FACT_W'((fp_prod + FP_PROD_W'(32768)) >> COEF_W);
    assign fc      = FACT_W'(65536) - FACT_W'(coef_reg);

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_accept   = in_valid && in_ready;
    assign result_load = (state_reg == ST_SUM) && (!out_valid_reg || out_ready);

    assign ctrl.mul_en = (state_reg == ST_MUL);
    assign ctrl.aux_en = (state_reg == ST_AUX);
    assign ctrl.mat_en = (state_reg == ST_MAT);

    genvar g;
    generate
        for (g = 0; g < VOIGT_COMPONENTS; g++)
        begin : g_lane
            vmsu_aux_lane u_lane (
                .clk         (clk),
                .ctrl        (ctrl),
                .strain      (strain_reg[g]),
                .prev_strain (prev_strain_reg[g]),
                .fc          (fc),
                .fp          (fp_reg),
                .ahi         (ahi[g]),
                .alo         (alo[g])
            );
        end
    endgenerate

    vmsu_merge u_merge (
        .clk              (clk),
        .ctrl             (ctrl),
        .ahi              (ahi),
        .alo              (alo),
        .normal_modulus   (normal_reg),
        .coupling_modulus (coupling_reg),
        .shear_modulus    (shear_reg),
        .decay_factor     (decay_reg),
        .prev_stress      (prev_stress_reg),
        .stress           (stress_sum)
    );

    // Sequencer, history and output register. A committed item replaces the
    // history at the same edge that its result enters the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            commit_reg    <= 1'b0;
            fp_reg        <= '0;
            for (int i = 0; i < VOIGT_COMPONENTS; i++)
            begin
                strain_reg[i]      <= '0;
                prev_strain_reg[i] <= '0;
                prev_stress_reg[i] <= '0;
                stress_reg[i]      <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && !result_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        for (int i = 0; i < VOIGT_COMPONENTS; i++)
                        begin
                            strain_reg[i] <= strain_in[i];
                        end
                        commit_reg <= commit;
                        state_reg  <= ST_FP;
                    end
                end
                ST_FP:
                begin
                    fp_reg    <= fp_next;
                    state_reg <= ST_MUL;
                end
                ST_MUL:  state_reg <= ST_AUX;
                ST_AUX:  state_reg <= ST_MAT;
                ST_MAT:  state_reg <= ST_SUM;
                ST_SUM:
                begin
                    if (result_load)
                    begin
                        for (int i = 0; i < VOIGT_COMPONENTS; i++)
                        begin
                            stress_reg[i] <= stress_sum[i];
                            if (commit_reg)
                            begin
                                prev_strain_reg[i] <= strain_reg[i];
                                prev_stress_reg[i] <= stress_sum[i];
                            end
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign stress_xx = stress_reg[0];
    assign stress_yy = stress_reg[1];
    assign stress_zz = stress_reg[2];
    assign stress_xy = stress_reg[3];
    assign stress_yz = stress_reg[4];
    assign stress_xz = stress_reg[5];

endmodule

[sv/vmsu_aux_lane.sv]
// ----------------------------------------------------------------------------
// vmsu_aux_lane: auxiliary strain of one Voigt component
// Weighs the current and previous strain by their Q1.16 factors, rounds the
// difference to Q.30 and splits it into a high and a low part.
// ----------------------------------------------------------------------------
module vmsu_aux_lane (
    input  logic                                   clk,
    input  vmsu_pkg::ctrl_t                        ctrl,
    input  vmsu_pkg::strain_t                      strain,
    input  vmsu_pkg::strain_t                      prev_strain,
    input  logic [vmsu_pkg::FACT_W-1:0]            fc,
    input  logic [vmsu_pkg::FACT_W-1:0]            fp,
    output vmsu_pkg::ahi_t                         ahi,
    output vmsu_pkg::alo_t                         alo
);
    import vmsu_pkg::*;

    localparam int PROD_W = STRAIN_W + FACT_W + 1;
    localparam int DIFF_W = PROD_W + 1;

    logic signed [PROD_W-1:0] p_cur_reg,  p_cur_next;
    logic signed [PROD_W-1:0] p_prev_reg, p_prev_next;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] rounded;
    ahi_t                     ahi_reg, ahi_next;
    alo_t                     alo_reg, alo_next;

    assign p_cur_next  = PROD_W'(strain)      * PROD_W'($signed({1'b0, fc}));
    assign p_prev_next = PROD_W'(prev_strain) * PROD_W'($signed({1'b0, fp}));

    // Round to nearest with ties upward, then drop the sixteen factor bits.
    assign diff     = DIFF_W'(p_cur_reg) - DIFF_W'(p_prev_reg);
    assign rounded  = (diff + DIFF_W'(32768)) >>> 16;
    assign ahi_next = rounded[AUX_W-1:ALO_W];
    assign alo_next = rounded[ALO_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            p_cur_reg  <= p_cur_next;
            p_prev_reg <= p_prev_next;
        end
        if (ctrl.aux_en)
        begin
            ahi_reg <= ahi_next;
            alo_reg <= alo_next;
        end
    end

    assign ahi = ahi_reg;
    assign alo = alo_reg;

endmodule

[sv/vmsu_merge.sv]
// ----------------------------------------------------------------------------
// vmsu_merge: elastic matrix product and decayed stress
// Combines the lanes' split aux strains through the isotropic matrix, adds
// the decayed previous stress and saturates each component.
// ----------------------------------------------------------------------------
module vmsu_merge (
    input  logic                          clk,
    input  vmsu_pkg::ctrl_t               ctrl,
    input  vmsu_pkg::ahi_t                ahi [vmsu_pkg::VOIGT_COMPONENTS],
    input  vmsu_pkg::alo_t                alo [vmsu_pkg::VOIGT_COMPONENTS],
    input  logic [vmsu_pkg::MOD_W-1:0]    normal_modulus,
    input  logic [vmsu_pkg::MOD_W-1:0]    coupling_modulus,
    input  logic [vmsu_pkg::MOD_W-1:0]    shear_modulus,
    input  logic [vmsu_pkg::COEF_W-1:0]   decay_factor,
    input  vmsu_pkg::stress_t             prev_stress [vmsu_pkg::VOIGT_COMPONENTS],
    output vmsu_pkg::stress_t             stress [vmsu_pkg::VOIGT_COMPONENTS]
);
    import vmsu_pkg::*;

    localparam int HI_W   = MOD_W + AHI_W + 3;
    localparam int LO_W   = MOD_W + ALO_W + 2;
    localparam int DEC_W  = STRESS_W + COEF_W;
    localparam int LOR_W  = LO_W + 1 - ALO_W;

    logic signed [MOD_W:0] nm_s, cm_s, sm_s;

    assign nm_s = $signed({1'b0, normal_modulus});
    assign cm_s = $signed({1'b0, coupling_modulus});
    assign sm_s = $signed({1'b0, shear_modulus});

    genvar g;
    generate
        for (g = 0; g < VOIGT_COMPONENTS; g++)
        begin : g_row
            logic signed [HI_W-1:0]  hi_a_reg, hi_a_next, hi_b_reg, hi_b_next;
            logic        [LO_W-1:0]  lo_a_reg, lo_a_next, lo_b_reg, lo_b_next;
            logic signed [DEC_W-1:0] dec_reg, dec_next;
            logic signed [HI_W:0]    hi_sum;
            logic        [LO_W:0]    lo_sum;
            logic        [LO_W:0]    lo_round;
            logic signed [DEC_W-1:0] dec_round;
            logic signed [SUM_W-1:0] total;

            if (g < NORMAL_ROWS)
            begin : g_normal
                logic signed [AHI_W:0] ahi_pair;
                logic        [ALO_W:0] alo_pair;

                // The two off-diagonal columns share the coupling modulus.
                assign ahi_pair  = (AHI_W+1)'(ahi[(g + 1) % NORMAL_ROWS])
                                 + (AHI_W+1)'(ahi[(g + 2) % NORMAL_ROWS]);
                assign alo_pair  = (ALO_W+1)'(alo[(g + 1) % NORMAL_ROWS])
                                 + (ALO_W+1)'(alo[(g + 2) % NORMAL_ROWS]);
                assign hi_a_next = HI_W'(nm_s) * HI_W'(ahi[g]);
                assign hi_b_next = HI_W'(cm_s) * HI_W'(ahi_pair);
                assign lo_a_next = LO_W'(normal_modulus)   * LO_W'(alo[g]);
                assign lo_b_next = LO_W'(coupling_modulus) * LO_W'(alo_pair);
            end
            else
            begin : g_shear
                assign hi_a_next = HI_W'(sm_s) * HI_W'(ahi[g]);
                assign hi_b_next = '0;
                assign lo_a_next = LO_W'(shear_modulus) * LO_W'(alo[g]);
                assign lo_b_next = '0;
            end

            assign dec_next = DEC_W'(prev_stress[g]) * DEC_W'($signed({1'b0, decay_factor}));

            always_ff @(posedge clk)
            begin
                if (ctrl.mat_en)
                begin
                    hi_a_reg <= hi_a_next;
                    hi_b_reg <= hi_b_next;
                    lo_a_reg <= lo_a_next;
                    lo_b_reg <= lo_b_next;
                    dec_reg  <= dec_next;
                end
            end

            // The low part carries fourteen fraction bits, the decayed stress
            // sixteen; both round to nearest with ties upward.
            assign hi_sum    = (HI_W+1)'(hi_a_reg) + (HI_W+1)'(hi_b_reg);
            assign lo_sum    = (LO_W+1)'(lo_a_reg) + (LO_W+1)'(lo_b_reg);
            assign lo_round  = (lo_sum + (LO_W+1)'(8192)) >> ALO_W;
            assign dec_round = (dec_reg + DEC_W'(32768)) >>> COEF_W;
            assign total     = SUM_W'(hi_sum)
                             + SUM_W'($signed({1'b0, lo_round[LOR_W-1:0]}))
                             + SUM_W'($signed(dec_round[STRESS_W-1:0]));
            assign stress[g] = sat_stress(total);
        end
    endgenerate

endmodule

[sv/vmsu_checker.sv]
// ----------------------------------------------------------------------------
// vmsu_checker: port-level checks for the Maxwell stress update
// Watches the handshakes of the top level and the spacing between items.
// ----------------------------------------------------------------------------
module vmsu_port_checks (
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input vmsu_pkg::stress_t stress_xx,
    input vmsu_pkg::stress_t stress_xz
);
    import vmsu_pkg::*;

    // A result that waits keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(stress_xx) && $stable(stress_xz))
        else $error("stalled result changed or vanished");

    // Only one item is in flight: acceptance closes the input for a while.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("input reopened before the item finished");

    // A new result never shows up right after an acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
        else $error("result appeared too early");

    // Loading a result frees the input at the same edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("input not ready after a result was loaded");

    // Register writes are never back-pressured.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind viscoelastic_maxwell_stress_update_top vmsu_port_checks u_vmsu_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stress_xx (stress_xx),
    .stress_xz (stress_xz)
);

[bench/vmsu_checker.sv]
// ----------------------------------------------------------------------------
// vmsu_checker: scoreboard for the Maxwell stress update
// Watches the configuration, strain and stress channels, keeps its own copy
// of the registers and the strain and stress history, predicts the stress
// item for every accepted strain item and compares each returned item with
// the oldest prediction.
// ----------------------------------------------------------------------------
module vmsu_checker
    import vmsu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  strain_t               strain_xx,
    input  strain_t               strain_yy,
    input  strain_t               strain_zz,
    input  strain_t               strain_xy,
    input  strain_t               strain_yz,
    input  strain_t               strain_xz,
    input  logic                  commit,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  stress_t               stress_xx,
    input  stress_t               stress_yy,
    input  stress_t               stress_zz,
    input  stress_t               stress_xy,
    input  stress_t               stress_yz,
    input  stress_t               stress_xz,
    output int                    failures,
    output int                    outstanding
);

    typedef logic [VOIGT_COMPONENTS-1:0][STRAIN_W-1:0] strain_set_t;
    typedef logic [VOIGT_COMPONENTS-1:0][STRESS_W-1:0] stress_set_t;

    logic [COEF_W-1:0] decay_q16;
    logic [COEF_W-1:0] coef_q16;
    logic [MOD_W-1:0]  normal_mod;
    logic [MOD_W-1:0]  coupling_mod;
    logic [MOD_W-1:0]  shear_mod;
    strain_set_t       strain_hist;
    stress_set_t       stress_hist;
    stress_set_t       stress_due_q [$];
    int                errors;

    string comp_name [VOIGT_COMPONENTS] = '{"xx", "yy", "zz", "xy", "yz", "xz"};

    // Stress for one strain item from the current registers and history.
    // All arithmetic is done in 64-bit signed integers, where it stays exact;
    // an arithmetic right shift gives the floor needed by each rounding.
    function automatic stress_set_t maxwell_stress(input strain_set_t strain);
        longint      d;
        longint      c;
        longint      fp;
        longint      fc;
        longint      nm;
        longint      cm;
        longint      sm;
        longint      cur;
        longint      old;
        longint      hi;
        longint      lo;
        longint      decayed;
        longint      total;
        longint      aux_hi [VOIGT_COMPONENTS];
        longint      aux_lo [VOIGT_COMPONENTS];
        strain_t     s_word;
        stress_t     p_word;
        stress_set_t res;
        int          i;
        int          j1;
        int          j2;
        d  = {48'd0, decay_q16};
        c  = {48'd0, coef_q16};
        nm = {32'd0, normal_mod};
        cm = {32'd0, coupling_mod};
        sm = {32'd0, shear_mod};
        fp = (d * (65536 + c) + 32768) >>> 16;
        fc = 65536 - c;
        for (i = 0; i < VOIGT_COMPONENTS; i++) begin
            s_word = strain[i];
            cur = s_word;
            s_word = strain_hist[i];
            old = s_word;
            cur = (cur * fc - old * fp + 32768) >>> 16;
            aux_hi[i] = cur >>> 14;
            aux_lo[i] = cur - aux_hi[i] * 16384;
        end
        for (i = 0; i < VOIGT_COMPONENTS; i++) begin
            if (i < NORMAL_ROWS) begin
                j1 = (i + 1) % NORMAL_ROWS;
                j2 = (i + 2) % NORMAL_ROWS;
                hi = nm * aux_hi[i] + cm * aux_hi[j1] + cm * aux_hi[j2];
                lo = nm * aux_lo[i] + cm * aux_lo[j1] + cm * aux_lo[j2];
            end else begin
                hi = sm * aux_hi[i];
                lo = sm * aux_lo[i];
            end
            p_word = stress_hist[i];
            old = p_word;
            decayed = (old * d + 32768) >>> 16;
            total = hi + ((lo + 8192) >>> 14) + decayed;
            if (total > longint'(STRESS_MAX)) begin
                total = STRESS_MAX;
            end else if (total < longint'(STRESS_MIN)) begin
                total = STRESS_MIN;
            end
            res[i] = total[STRESS_W-1:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin : scoreboard
        strain_set_t strain_now;
        stress_set_t stress_new;
        stress_set_t stress_got;
        stress_set_t stress_want;
        stress_t     want;
        stress_t     got;
        int          i;
        if (!rst_n) begin
            decay_q16    = '0;
            coef_q16     = '0;
            normal_mod   = '0;
            coupling_mod = '0;
            shear_mod    = '0;
            strain_hist  = '0;
            stress_hist  = '0;
            stress_due_q.delete();
            errors       = 0;
            failures    <= 0;
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DECAY:    decay_q16    = cfg_data[COEF_W-1:0];
                    CFG_COEF:     coef_q16     = cfg_data[COEF_W-1:0];
                    CFG_NORMAL:   normal_mod   = cfg_data[MOD_W-1:0];
                    CFG_COUPLING: coupling_mod = cfg_data[MOD_W-1:0];
                    CFG_SHEAR:    shear_mod    = cfg_data[MOD_W-1:0];
                    default:      ;
                endcase
            end
            if (in_valid && in_ready) begin
                strain_now = {strain_xz, strain_yz, strain_xy,
                              strain_zz, strain_yy, strain_xx};
                stress_new = maxwell_stress(strain_now);
                stress_due_q.push_back(stress_new);
                if (commit) begin
                    strain_hist = strain_now;
                    stress_hist = stress_new;
                end
            end
            if (out_valid && out_ready) begin
                stress_got = {stress_xz, stress_yz, stress_xy,
                              stress_zz, stress_yy, stress_xx};
                if (stress_due_q.size() == 0) begin
                    errors++;
                    $display("%0t: stress item expected none, actual stress_xx %0d",
                             $time, stress_xx);
                end else begin
                    stress_want = stress_due_q.pop_front();
                    for (i = 0; i < VOIGT_COMPONENTS; i++) begin
                        want = stress_want[i];
                        got  = stress_got[i];
                        if (got !== want) begin
                            errors++;
                            $display("%0t: stress_%s expected %0d, actual %0d",
                                     $time, comp_name[i], want, got);
                        end
                    end
                end
            end
            failures    <= errors;
            outstanding <= stress_due_q.size();
        end
    end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the Maxwell stress update block
// Drives strain items and register writes, stalls the stress output at
// random and twice for a long stretch, and leaves prediction and comparison
// to the checker; the verdict comes from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;

    import vmsu_pkg::*;

    typedef logic [VOIGT_COMPONENTS-1:0][STRAIN_W-1:0] strain_set_t;

    // Strain value families used by the random stimulus.
    typedef enum int {
        STRAIN_SMALL,
        STRAIN_FULL,
        STRAIN_CORNER
    } strain_mix_t;

    localparam int      CYCLE_LIMIT    = 1000000;
    localparam int      RANDOM_PHASES  = 8;
    localparam int      PHASE_ITEMS    = 230;
    localparam int      LONG_HOLD      = 400;
    localparam strain_t STRAIN_TOP     = {1'b0, {(STRAIN_W-1){1'b1}}};
    localparam strain_t STRAIN_BOTTOM  = {1'b1, {(STRAIN_W-1){1'b0}}};
    localparam logic [COEF_W-1:0] Q16_TOP = '1;
    localparam logic [MOD_W-1:0]  MOD_TOP = '1;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    strain_t               strain_xx;
    strain_t               strain_yy;
    strain_t               strain_zz;
    strain_t               strain_xy;
    strain_t               strain_yz;
    strain_t               strain_xz;
    logic                  commit;
    logic                  out_valid;
    logic                  out_ready;
    stress_t               stress_xx;
    stress_t               stress_yy;
    stress_t               stress_zz;
    stress_t               stress_xy;
    stress_t               stress_yz;
    stress_t               stress_xz;
    int                    failures;
    int                    outstanding;

    viscoelastic_maxwell_stress_update_top u_dut (.*);

    vmsu_checker u_checker (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sender gap in cycles: mostly none or short, now and then a long one.
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Small strains keep the stresses in range so that the history builds up
    // over many items; full-range and corner values drive saturation.
    function automatic strain_t rand_strain(input strain_mix_t mix);
        int v;
        case (mix)
            STRAIN_SMALL: begin
                v = $urandom_range(0, 33554432);
                return strain_t'(v - 16777216);
            end
            STRAIN_FULL: return strain_t'($urandom());
            default: begin
                case ($urandom_range(0, 4))
                    0:       return STRAIN_TOP;
                    1:       return STRAIN_BOTTOM;
                    2:       return '0;
                    3:       return '1;
                    default: return strain_t'(1);
                endcase
            end
        endcase
    endfunction

    function automatic strain_set_t random_set();
        strain_set_t s;
        int          r;
        int          i;
        r = $urandom_range(0, 99);
        for (i = 0; i < VOIGT_COMPONENTS; i++) begin
            if (r < 55) begin
                s[i] = rand_strain(STRAIN_SMALL);
            end else if (r < 85) begin
                s[i] = rand_strain(STRAIN_FULL);
            end else begin
                s[i] = rand_strain(strain_mix_t'($urandom_range(0, 2)));
            end
        end
        return s;
    endfunction

    function automatic strain_set_t uniform_set(input strain_t v);
        return {VOIGT_COMPONENTS{v}};
    endfunction

    function automatic logic [COEF_W-1:0] pick_q16();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return '0;
        end else if (r < 30) begin
            return Q16_TOP;
        end
        return COEF_W'($urandom_range(0, 65535));
    endfunction

    // Moduli are mostly modest so that only part of the items saturate.
    function automatic logic [MOD_W-1:0] pick_modulus();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return '0;
        end else if (r < 25) begin
            return MOD_TOP;
        end else if (r < 70) begin
            return $urandom_range(0, 4096);
        end else if (r < 90) begin
            return $urandom_range(0, 1048576);
        end
        return $urandom();
    endfunction

    // One register write. cfg_valid is left high so that a following write
    // goes out back to back; configure lowers it after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Writes all five registers. The 16-bit registers get random upper bits,
    // which the block has to drop. A stray write to an unused index may follow.
    task automatic configure(input logic [COEF_W-1:0] decay, input logic [COEF_W-1:0] coef,
                             input logic [MOD_W-1:0] normal, input logic [MOD_W-1:0] coupling,
                             input logic [MOD_W-1:0] shear, input logic stray);
        write_reg(CFG_DECAY, {16'($urandom_range(0, 65535)), decay});
        write_reg(CFG_COEF, {16'($urandom_range(0, 65535)), coef});
        write_reg(CFG_NORMAL, normal);
        write_reg(CFG_COUPLING, coupling);
        write_reg(CFG_SHEAR, shear);
        if (stray) begin
            write_reg(CFG_IDX_W'(CFG_SHEAR + 1 + $urandom_range(0, 2)), $urandom());
        end
        cfg_valid <= 1'b0;
    endtask

    // Offers one strain item after an optional gap and returns at the clock
    // edge where it is accepted. in_valid stays high on return, so a next item
    // with no gap follows without a drop in valid.
    task automatic offer_strain(input strain_set_t s, input logic keep, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        strain_xx <= s[0];
        strain_yy <= s[1];
        strain_zz <= s[2];
        strain_xy <= s[3];
        strain_yz <= s[4];
        strain_xz <= s[5];
        commit    <= keep;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stops offering and waits until the checker expects nothing more, so the
    // block is idle and its registers may be rewritten.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Result side. Stalls come in alternating stretches: a quiet one with
    // out_ready held high and a busy one with random stalls. Twice in the run
    // the output is held off for a long time while the sender keeps offering,
    // which fills the block and must stall its input.
    initial begin : result_sink
        int stall_left;
        int results_seen;
        int cyc;
        stall_left   = 0;
        results_seen = 0;
        cyc          = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            cyc++;
            if (out_valid && out_ready) begin
                results_seen++;
                if (results_seen == 300 || results_seen == 1500) begin
                    stall_left = LONG_HOLD;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if ((cyc / 250) % 2 == 1 && $urandom_range(0, 99) < 30) begin
                if ($urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(10, 40);
                end else begin
                    stall_left = $urandom_range(0, 2);
                end
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Ends the run if the block hangs.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        strain_set_t mixed;
        int          ph;
        int          k;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        strain_xx <= '0;
        strain_yy <= '0;
        strain_zz <= '0;
        strain_xy <= '0;
        strain_yz <= '0;
        strain_xz <= '0;
        commit    <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Decay at its largest value, the closest the block gets to one, with
        // modest moduli: strain extremes with and without commit. An item
        // without commit must leave the history alone for the next one.
        configure(Q16_TOP, '0, 32'd1000, 32'd400, 32'd300, 1'b0);
        offer_strain(uniform_set(STRAIN_TOP), 1'b1, rand_gap());
        offer_strain(uniform_set(STRAIN_BOTTOM), 1'b1, rand_gap());
        offer_strain(uniform_set('0), 1'b0, rand_gap());
        offer_strain(uniform_set('1), 1'b1, rand_gap());
        mixed = {strain_t'(32'h4000_0000), strain_t'(1), strain_t'('1),
                 strain_t'('0), STRAIN_BOTTOM, STRAIN_TOP};
        offer_strain(mixed, 1'b1, rand_gap());
        offer_strain(uniform_set('0), 1'b1, rand_gap());

        // Every register at its top value: both saturation directions, the
        // clamped stress kept as history and decayed in the following items.
        // Writes to unused indexes must not disturb any register.
        settle();
        configure(Q16_TOP, Q16_TOP, MOD_TOP, MOD_TOP, MOD_TOP, 1'b1);
        write_reg(CFG_IDX_W'(CFG_SHEAR + 1), '1);
        write_reg(CFG_IDX_W'(CFG_SHEAR + 3), '1);
        cfg_valid <= 1'b0;
        offer_strain(uniform_set(STRAIN_TOP), 1'b1, rand_gap());
        offer_strain(uniform_set('0), 1'b1, rand_gap());
        offer_strain(uniform_set(STRAIN_BOTTOM), 1'b1, rand_gap());
        offer_strain(uniform_set(STRAIN_BOTTOM), 1'b0, rand_gap());
        offer_strain(random_set(), 1'b1, rand_gap());

        // No decay and zero moduli: the stress must come out as zero.
        settle();
        configure('0, Q16_TOP, '0, '0, '0, 1'b0);
        offer_strain(uniform_set(STRAIN_TOP), 1'b1, rand_gap());
        offer_strain(uniform_set(STRAIN_BOTTOM), 1'b1, rand_gap());

        // Half decay and coefficient with lopsided moduli.
        settle();
        configure(16'h8000, 16'h8000, 32'h8000_0000, 32'd1, MOD_TOP, 1'b0);
        for (k = 0; k < 4; k++) begin
            offer_strain(random_set(), k[0], rand_gap());
        end

        // Random phases, each with fresh register values. Most items commit,
        // so the history carries over from item to item as in real use.
        // Phases 0 and 4 offer items back to back with no gaps.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            configure(pick_q16(), pick_q16(), pick_modulus(), pick_modulus(),
                      pick_modulus(), 1'($urandom_range(0, 1)));
            for (k = 0; k < PHASE_ITEMS; k++) begin
                offer_strain(random_set(), $urandom_range(0, 9) < 8,
                             (ph % 4 == 0) ? 0 : rand_gap());
            end
        end

        // Drain, then give a stray late result time to show up.
        settle();
        repeat (12) @(posedge clk);
        if (failures == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
